// ===== hdl/lap_pkg.sv =====
// ----------------------------------------------------------------------------
// lap_pkg
// Types and character codes shared by the listing annotation parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lap_pkg;

  localparam int unsigned CHAR_W = 16;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned OFF_W  = 19;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 16'h0024;
  localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 16'h003B;
  localparam logic [CHAR_W-1:0] CH_BOM   = 16'hFEFF;
  localparam logic [CHAR_W-1:0] CH_SWAP  = 16'hFFFE;

  typedef struct packed {
    logic [ADDR_W-1:0] entry_address;
    logic              has_comment;
    logic              is_data;
    logic              is_block_comment;
    logic [OFF_W-1:0]  comment_offset;
    logic              rejected;
    logic              last_of_run;
  } rec_t;

  // records raised by one character, in delivery order
  typedef struct packed {
    rec_t       slot0;
    rec_t       slot1;
    logic [1:0] count;
  } step_out_t;

endpackage : lap_pkg

`default_nettype wire

// ===== hdl/listing_annotation_parser.sv =====
// ----------------------------------------------------------------------------
// listing_annotation_parser
// Parses an annotated assembly listing, one UTF-16 character per word, and
// streams out block comment, line comment and data line records.
// ----------------------------------------------------------------------------
//  channel  dir  word                        handshake
//  s_axis   in   one character               tvalid/tready
//  m_axis   out  one annotation record       tvalid/tready, tlast
//
//  One character per cycle while the buffer has room; each raises up to two
//  records in the same cycle. Records queue in a four-word output buffer;
//  input is taken while at least two buffer words are free, so a character's
//  records always fit. Reset clears parse state and empties the buffer.
//  A stalled output stops input once three words wait in the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module listing_annotation_parser
  import lap_pkg::*;
#(
  parameter int unsigned MAX_TEXT_CHARS = 524288
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [15:0] text_char
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,  // [15:0] entry_address, [34:16] comment_offset
  output logic [3:0]       m_axis_tuser_o,  // [0] has_comment, [1] is_data,
                                            // [2] is_block_comment, [3] rejected
  output logic             m_axis_tlast_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic             in_acc, out_acc;
  step_out_t        step;
  rec_t             fifo_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  rec_t             head;

  assign s_axis_tready_o = (cnt_q <= CNT_W'(DEPTH - 2));
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;

  lap_core #(
    .MAX_TEXT_CHARS(MAX_TEXT_CHARS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (in_acc),
    .char_i (s_axis_tdata_i),
    .step_o (step)
  );

  assign wr_d  = wr_q + PTR_W'(step.count);
  assign rd_d  = rd_q + PTR_W'(out_acc);
  assign cnt_d = cnt_q + CNT_W'(step.count) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.count != 2'd0) fifo_q[wr_q] <= step.slot0;
    if (step.count == 2'd2) fifo_q[wr_q + 1'b1] <= step.slot1;
  end

  assign head = fifo_q[rd_q];

  assign m_axis_tdata_o = {5'b0, head.comment_offset, head.entry_address};
  assign m_axis_tuser_o = {head.rejected, head.is_block_comment, head.is_data,
                           head.has_comment};
  assign m_axis_tlast_o = head.last_of_run;

  // buffer never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("output buffer overflow");

  // records arise only from an accepted character
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.count != 2'd0) |-> in_acc)
    else $error("record raised without an accepted character");

  // with two records, only the second closes the run
  a_last_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.count == 2'd2) |-> (!step.slot0.last_of_run && step.slot1.last_of_run))
    else $error("run end marked on wrong record");

  // buffer count tracks pushes and pops
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.count == 2'd0 && !out_acc) |=> $stable(cnt_q))
    else $error("buffer count moved while idle");

endmodule : listing_annotation_parser

`default_nettype wire

// ===== hdl/lap_core.sv =====
// ----------------------------------------------------------------------------
// lap_core
// Line state tracker: updates the parse state for one character and builds
// the records that character raises.
// ----------------------------------------------------------------------------
`default_nettype none

module lap_core
  import lap_pkg::*;
#(
  parameter int unsigned MAX_TEXT_CHARS = 524288
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [CHAR_W-1:0] char_i,
  output step_out_t              step_o
);

  localparam int unsigned POS_W = $clog2(MAX_TEXT_CHARS);
  localparam int unsigned EXT_W = POS_W + OFF_W;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LSTART,
    PH_SKIP,
    PH_ADDR,
    PH_SEP,
    PH_SCAN,
    PH_COMMENT
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ADDR_W-1:0] acc_q, acc_d;
  logic              dir_q, dir_d;
  logic              bp_q, bp_d;
  logic [POS_W-1:0]  boff_q, boff_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              done_q, done_d;

  logic [POS_W:0]    pos_inc;
  logic [EXT_W-1:0]  pos_ext, boff_ext;
  logic              is_eol, is_digit, is_sep;
  logic              blk_v, scan_v;
  rec_t              blk_rec, scan_rec;
  phase_e            eph;
  logic              scan_go, dir_eff;

  assign is_eol   = (char_i == CH_LF) || (char_i == CH_CR);
  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_sep   = (char_i == CH_SPACE) || (char_i == CH_TAB) ||
                    (char_i == CH_DOLLAR) || (char_i == CH_COLON);
  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign pos_ext  = EXT_W'(pos_q);
  assign boff_ext = EXT_W'(boff_q);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    dir_d    = dir_q;
    bp_d     = bp_q;
    boff_d   = boff_q;
    pos_d    = pos_q;
    done_d   = done_q;
    blk_v    = 1'b0;
    scan_v   = 1'b0;
    scan_go  = 1'b0;
    dir_eff  = dir_q;
    eph      = (phase_q == PH_FIRST) ? PH_LSTART : phase_q;
    blk_rec  = '0;
    scan_rec = '0;
    blk_rec.entry_address    = acc_q;
    blk_rec.is_block_comment = 1'b1;
    blk_rec.comment_offset   = boff_ext[OFF_W-1:0];
    scan_rec.entry_address   = acc_q;

    if (take_i && !done_q) begin
      pos_d = (pos_inc >= (POS_W+1)'(MAX_TEXT_CHARS)) ? '0 : pos_inc[POS_W-1:0];

      if (phase_q == PH_FIRST &&
          ((char_i == CH_NUL) || (char_i == CH_SWAP))) begin
        done_d            = 1'b1;
        scan_v            = 1'b1;
        scan_rec.rejected = 1'b1;
      end else if (phase_q == PH_FIRST && char_i == CH_BOM) begin
        phase_d = PH_LSTART;
      end else if (char_i == CH_NUL) begin
        done_d = 1'b1;
        if (phase_q == PH_FIRST) phase_d = PH_LSTART;
      end else begin
        unique case (eph)
          PH_LSTART: begin
            phase_d = PH_LSTART;
            if (is_digit) begin
              acc_d   = ADDR_W'(char_i[3:0]);
              phase_d = PH_ADDR;
            end else if (!is_eol) begin
              bp_d    = (char_i == CH_SEMI);
              boff_d  = pos_q;
              phase_d = PH_SKIP;
            end
          end
          PH_SKIP, PH_COMMENT: begin
            if (is_eol) phase_d = PH_LSTART;
          end
          PH_ADDR: begin
            if (is_digit) begin
              acc_d = {acc_q[ADDR_W-4:0], 3'b000} + ADDR_W'(char_i[3:0]);
            end else begin
              // the terminator stays in place and is parsed as the first
              // character after the address
              blk_v = bp_q;
              bp_d  = 1'b0;
              if (is_sep) begin
                phase_d = PH_SEP;
              end else begin
                dir_eff = (char_i == CH_DOT);
                scan_go = 1'b1;
              end
            end
          end
          PH_SEP: begin
            if (!is_sep) begin
              dir_eff = (char_i == CH_DOT);
              scan_go = 1'b1;
            end
          end
          PH_SCAN: scan_go = 1'b1;
          default: phase_d = PH_LSTART;
        endcase

        if (scan_go) begin
          dir_d   = dir_eff;
          phase_d = PH_SCAN;
          if (char_i == CH_SEMI) begin
            scan_v                  = 1'b1;
            scan_rec.has_comment    = 1'b1;
            scan_rec.is_data        = dir_eff;
            scan_rec.comment_offset = pos_ext[OFF_W-1:0];
            phase_d                 = PH_COMMENT;
          end else if (is_eol) begin
            scan_v           = dir_eff;
            scan_rec.is_data = 1'b1;
            phase_d          = PH_LSTART;
          end
        end
      end
    end
  end

  // pack records in order and mark the final one
  always_comb begin
    step_o       = '0;
    step_o.count = 2'(blk_v) + 2'(scan_v);
    if (blk_v) begin
      step_o.slot0             = blk_rec;
      step_o.slot0.last_of_run = !scan_v;
      step_o.slot1             = scan_rec;
      step_o.slot1.last_of_run = 1'b1;
    end else begin
      step_o.slot0             = scan_rec;
      step_o.slot0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      acc_q   <= '0;
      dir_q   <= 1'b0;
      bp_q    <= 1'b0;
      boff_q  <= '0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dir_q   <= dir_d;
      bp_q    <= bp_d;
      boff_q  <= boff_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
    end
  end

endmodule : lap_core

`default_nettype wire

// ===== tb/sv/lap_record_checker.sv =====
// ----------------------------------------------------------------------------
// lap_record_checker
// Watches the character and record channels of the listing annotation
// parser, predicts the records each accepted character should raise and
// compares every delivered record against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lap_record_checker
  import lap_pkg::*;
#(
  parameter int unsigned MAX_TEXT_CHARS = 524288
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char_valid_i,
  input  logic        char_ready_i,
  input  logic [15:0] char_i,
  input  logic        rec_valid_i,
  input  logic        rec_ready_i,
  input  logic [39:0] rec_data_i,     // [15:0] entry_address, [34:16] comment_offset
  input  logic [3:0]  rec_user_i,     // [0] has_comment, [1] is_data,
                                      // [2] is_block_comment, [3] rejected
  input  logic        rec_last_i,
  output int          error_count_o,
  output int          pending_o,
  output int          block_count_o,
  output int          comment_count_o,
  output int          data_count_o
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LINE_START,
    PH_SKIP_LINE,
    PH_ADDRESS,
    PH_SEPARATOR,
    PH_SCAN,
    PH_COMMENT
  } parse_phase_e;

  parse_phase_e      phase;
  logic [ADDR_W-1:0] address_accum;
  logic              directive_seen;
  logic              block_pending;
  logic [OFF_W-1:0]  block_offset;
  int unsigned       char_pos;
  logic              text_done;

  rec_t expected_records [$];

  function automatic logic is_eol(input logic [15:0] c);
    return c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic is_digit(input logic [15:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_separator(input logic [15:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_DOLLAR || c == CH_COLON;
  endfunction

  // Advance the parse by one character and queue the records it raises.
  task automatic parse_char(input logic [15:0] c);
    rec_t        made [2];
    int          n;
    int unsigned pos;
    logic        run_sep;
    logic        run_scan;
    n        = 0;
    run_sep  = 1'b0;
    run_scan = 1'b0;
    pos      = char_pos;
    if (text_done) return;
    char_pos = (pos + 1 >= MAX_TEXT_CHARS) ? 0 : pos + 1;

    if (phase == PH_FIRST && (c == CH_NUL || c == CH_SWAP)) begin
      text_done         = 1'b1;
      made[0]           = '0;
      made[0].rejected  = 1'b1;
      n                 = 1;
    end else if (phase == PH_FIRST && c == CH_BOM) begin
      phase = PH_LINE_START;
    end else if (c == CH_NUL) begin
      text_done = 1'b1;
    end else begin
      if (phase == PH_FIRST) phase = PH_LINE_START;
      case (phase)
        PH_LINE_START: begin
          if (is_digit(c)) begin
            address_accum = c - CH_ZERO;
            phase         = PH_ADDRESS;
          end else if (!is_eol(c)) begin
            block_pending = (c == CH_SEMI);
            block_offset  = OFF_W'(pos);
            phase         = PH_SKIP_LINE;
          end
        end
        PH_SKIP_LINE, PH_COMMENT: begin
          if (is_eol(c)) phase = PH_LINE_START;
        end
        PH_ADDRESS: begin
          if (is_digit(c)) begin
            address_accum = {address_accum[ADDR_W-4:0], 3'b000} + (c - CH_ZERO);
          end else begin
            if (block_pending) begin
              made[n]                  = '0;
              made[n].entry_address    = address_accum;
              made[n].is_block_comment = 1'b1;
              made[n].comment_offset   = block_offset;
              n++;
              block_pending = 1'b0;
            end
            // the terminator is parsed again as the first character after the address
            phase   = PH_SEPARATOR;
            run_sep = 1'b1;
          end
        end
        PH_SEPARATOR: run_sep = 1'b1;
        PH_SCAN:      run_scan = 1'b1;
        default:      phase = PH_LINE_START;
      endcase

      if (run_sep && !is_separator(c)) begin
        directive_seen = (c == CH_DOT);
        phase          = PH_SCAN;
        run_scan       = 1'b1;
      end

      if (run_scan) begin
        if (c == CH_SEMI) begin
          made[n]                = '0;
          made[n].entry_address  = address_accum;
          made[n].has_comment    = 1'b1;
          made[n].is_data        = directive_seen;
          made[n].comment_offset = OFF_W'(pos);
          n++;
          phase = PH_COMMENT;
        end else if (is_eol(c)) begin
          if (directive_seen) begin
            made[n]               = '0;
            made[n].entry_address = address_accum;
            made[n].is_data       = 1'b1;
            n++;
          end
          phase = PH_LINE_START;
        end
      end
    end

    if (n > 0) made[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_records.push_back(made[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rec_t want;
    rec_t got;
    if (!rst_ni) begin
      phase          = PH_FIRST;
      address_accum  = '0;
      directive_seen = 1'b0;
      block_pending  = 1'b0;
      block_offset   = '0;
      char_pos       = 0;
      text_done      = 1'b0;
      expected_records.delete();
      error_count_o   = 0;
      block_count_o   = 0;
      comment_count_o = 0;
      data_count_o    = 0;
    end else begin
      if (char_valid_i && char_ready_i) parse_char(char_i);

      if (rec_valid_i && rec_ready_i) begin
        got.entry_address    = rec_data_i[15:0];
        got.comment_offset   = rec_data_i[34:16];
        got.has_comment      = rec_user_i[0];
        got.is_data          = rec_user_i[1];
        got.is_block_comment = rec_user_i[2];
        got.rejected         = rec_user_i[3];
        got.last_of_run      = rec_last_i;
        if (got.is_block_comment) block_count_o++;
        else if (got.has_comment) comment_count_o++;
        else if (got.is_data) data_count_o++;

        if (expected_records.size() == 0) begin
          $error("record with no prediction waiting: address 0x%0h user 0x%0h",
                 got.entry_address, rec_user_i);
          error_count_o++;
        end else begin
          want = expected_records.pop_front();
          check_field("entry_address", 32'(want.entry_address),
                      32'(got.entry_address));
          check_field("has_comment", 32'(want.has_comment), 32'(got.has_comment));
          check_field("is_data", 32'(want.is_data), 32'(got.is_data));
          check_field("is_block_comment", 32'(want.is_block_comment),
                      32'(got.is_block_comment));
          check_field("comment_offset", 32'(want.comment_offset),
                      32'(got.comment_offset));
          check_field("rejected", 32'(want.rejected), 32'(got.rejected));
          check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
      end
    end
    pending_o = expected_records.size();
  end

endmodule : lap_record_checker

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds one annotated listing, byte-order mark first, end of text and dropped
// characters last, into the listing annotation parser: a directed opening, then randomly
// shaped comment, address, directive and noise lines, with random gaps on
// both channels. The checker alongside predicts and compares every record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lap_pkg::*;

  localparam int unsigned MAX_CHARS     = 524288;
  localparam int          RANDOM_CHARS  = 1250;
  localparam int          CALM_FROM     = 1100;
  localparam logic [15:0] CH_LETTER     = 16'h0078;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        char_valid = 1'b0;
  logic        char_ready;
  logic [15:0] char_data = '0;
  logic        rec_valid;
  logic        rec_ready = 1'b0;
  logic [39:0] rec_data;
  logic [3:0]  rec_user;
  logic        rec_last;

  int error_count;
  int pending;
  int block_count;
  int comment_count;
  int data_count;

  logic        idle_enabled = 1'b1;
  int          ready_hold = 0;
  int          sent_chars = 0;
  logic [15:0] directed_text [$];
  logic [15:0] line_text [$];

  always #2 clk_i = ~clk_i;

  listing_annotation_parser #(
    .MAX_TEXT_CHARS(MAX_CHARS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(char_valid),
    .s_axis_tready_o(char_ready),
    .s_axis_tdata_i (char_data),
    .m_axis_tvalid_o(rec_valid),
    .m_axis_tready_i(rec_ready),
    .m_axis_tdata_o (rec_data),
    .m_axis_tuser_o (rec_user),
    .m_axis_tlast_o (rec_last)
  );

  lap_record_checker #(
    .MAX_TEXT_CHARS(MAX_CHARS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_valid_i   (char_valid),
    .char_ready_i   (char_ready),
    .char_i         (char_data),
    .rec_valid_i    (rec_valid),
    .rec_ready_i    (rec_ready),
    .rec_data_i     (rec_data),
    .rec_user_i     (rec_user),
    .rec_last_i     (rec_last),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .block_count_o  (block_count),
    .comment_count_o(comment_count),
    .data_count_o   (data_count)
  );

  // Record sink: stall in random bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      rec_ready  <= 1'b0;
    end else if (idle_enabled && $urandom_range(0, 11) == 0) begin
      ready_hold <= $urandom_range(0, 15);
      rec_ready  <= 1'b0;
    end else begin
      rec_ready <= 1'b1;
    end
  end

  function automatic logic [15:0] any_char();
    return 16'($urandom_range(1, 16'hFFFF));
  endfunction

  function automatic logic [15:0] body_char();
    logic [15:0] v;
    if ($urandom_range(0, 7) == 0) return any_char();
    v = 16'($urandom_range(16'h0020, 16'h007E));
    if (v == CH_SEMI) v = CH_DOT;
    return v;
  endfunction

  function automatic logic [15:0] sep_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_DOLLAR;
      default: return CH_COLON;
    endcase
  endfunction

  task automatic push_eol();
    if ($urandom_range(0, 3) == 0) begin
      line_text.push_back(CH_CR);
      line_text.push_back(CH_LF);
    end else begin
      line_text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
    end
  endtask

  // Build one line of listing text, mostly well formed.
  task automatic build_line();
    int kind;
    int ndig;
    kind = $urandom_range(0, 19);
    line_text.delete();
    if (kind < 4) begin
      line_text.push_back(CH_SEMI);
      repeat ($urandom_range(0, 6)) line_text.push_back(body_char());
      push_eol();
    end else if (kind < 15) begin
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 11) : $urandom_range(1, 4);
      repeat (ndig) line_text.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
      repeat ($urandom_range(0, 3)) line_text.push_back(sep_char());
      if ($urandom_range(0, 1)) line_text.push_back(CH_DOT);
      repeat ($urandom_range(0, 5)) line_text.push_back(body_char());
      if ($urandom_range(0, 1)) begin
        line_text.push_back(CH_SEMI);
        repeat ($urandom_range(0, 6)) line_text.push_back(any_char());
      end
      push_eol();
    end else if (kind < 16) begin
      push_eol();
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 8)) line_text.push_back(any_char());
      push_eol();
    end else begin
      line_text.push_back($urandom_range(0, 1) ? CH_DOT : CH_LETTER);
      repeat ($urandom_range(0, 5)) line_text.push_back(body_char());
      push_eol();
    end
  endtask

  // Offer one character and hold it until the parser takes it.
  task automatic send_char(input logic [15:0] c);
    logic took;
    if (idle_enabled && $urandom_range(0, 9) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    char_valid <= 1'b1;
    char_data  <= c;
    do begin
      @(negedge clk_i);
      took = char_ready;
      @(posedge clk_i);
    end while (!took);
    sent_chars++;
  endtask

  initial begin
    int waited;
    directed_text = '{
      CH_BOM, CH_SEMI, CH_LF,
      CH_NINE, CH_NINE - 16'd1, CH_ZERO + 16'd7, CH_SEMI, CH_SPACE, CH_LETTER, CH_CR,
      CH_ZERO + 16'd1, CH_DOT, CH_LF,
      CH_ZERO, CH_DOLLAR, CH_COLON, CH_TAB, 16'hFFFF, CH_SEMI, CH_LF,
      CH_BOM, CH_LF, CH_SWAP, CH_LF
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_text[i]) send_char(directed_text[i]);

    // hold off until the parser has drained every record
    char_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);

    while (sent_chars < RANDOM_CHARS) begin
      if (sent_chars >= CALM_FROM) idle_enabled = 1'b0;
      build_line();
      foreach (line_text[i]) send_char(line_text[i]);
    end

    // end the text inside an address, then feed characters that must be dropped
    send_char(CH_SEMI);
    send_char(CH_LF);
    send_char(CH_ZERO + 16'd1);
    send_char(CH_ZERO + 16'd2);
    send_char(CH_NUL);
    send_char(CH_ZERO + 16'd5);
    send_char(CH_SEMI);
    send_char(CH_LF);
    char_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);

    $display("Covered %0d characters of one listing, end of text and trailing input included.",
             sent_chars);
    $display("Records checked: %0d block comments, %0d line comments, %0d data lines.",
             block_count, comment_count, data_count);
    if (pending != 0) $error("%0d predicted records never arrived", pending);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1000000;
    $error("run did not finish in the time allowed");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule : testbench
